### rtl/lte_pkg.sv
`timescale 1ns / 1ps
// lte_pkg: shared types and constants for the lease table engine
// used by lease_table_engine; depends on nothing

package lte_pkg;

  // command codes
  localparam logic [2:0] CMD_LOOKUP = 3'd0;
  localparam logic [2:0] CMD_WRITE  = 3'd1;
  localparam logic [2:0] CMD_DELETE = 3'd2;
  localparam logic [2:0] CMD_SWAP   = 3'd3;
  localparam logic [2:0] CMD_IGNORE = 3'd4;
  localparam logic [2:0] CMD_READ   = 3'd5;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEASE_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_IP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_MASK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 3'd3;

  localparam logic [5:0]  LEASE_COUNT_RST  = 6'd32;
  localparam logic [31:0] BASE_IP_RST      = 32'h0000_0000;
  localparam logic [31:0] SUBNET_MASK_RST  = 32'hFFFF_FF00;
  localparam logic [7:0]  START_OFFSET_RST = 8'd1;

  localparam logic [7:0] NOT_FOUND = 8'hFF;
  localparam logic [1:0] ST_AVAILABLE = 2'd0;

  // seconds from milliseconds
  localparam logic [10:0] MS_PER_SEC = 11'd1000;

  // ceil(2^38 / 1000), applied as two 16-bit halves; exact for any 32-bit magnitude
  localparam logic [15:0] RECIP_MS_LO    = 16'h4DD3;
  localparam logic [15:0] RECIP_MS_HI    = 16'h1062;
  localparam int unsigned RECIP_MS_SHIFT = 38;

  typedef struct packed {
    logic [47:0] mac;
    logic [31:0] expiry;
    logic [1:0]  status;
    logic        ignore_flag;
  } entry_t;

endpackage

### rtl/lease_table_engine.sv
`timescale 1ns / 1ps
// lease_table_engine: address lease table with lookup, edit and read commands
// depends on lte_pkg
//
// Usage: one command per input transaction on the in_ channel (valid/ready),
// one result transaction per command on the out_ channel (valid/ready).
// Configuration registers are written through the cfg_ channel, which is
// always ready; write them only while no command is in flight.
// Commands run on a small sequencer around one table memory with a single
// registered read port and a single write port. Write, delete and unused codes
// finish straight after dispatch; set ignore reads and then writes its entry;
// swap reads both entries and writes them back; read passes through the shared
// 32x16 reciprocal multiply that divides by 1000 for seconds_delta, low half
// then high half; lookup scans the active entries up to a hit, and on a miss
// runs the expiry sweep after the scan.
// The block takes a new command only when idle, that is once the last result
// is loaded. The result sits in an output register: a stalled receiver does
// not stop the next command from being accepted, only its result is held back.
// Reset (rst_n low, synchronous) clears every entry's valid bit, so all
// entries read as blank, and loads the register reset values; no sweep.

module lease_table_engine
  import lte_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_command,
  input  logic [7:0]           in_index_a,
  input  logic [7:0]           in_index_b,
  input  logic [47:0]          in_mac_in,
  input  logic signed [31:0]   in_time_now,
  input  logic signed [31:0]   in_expiry_in,
  input  logic [1:0]           in_status_in,
  input  logic                 in_ignore_in,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_found,
  output logic [7:0]           out_entry_index,
  output logic                 out_index_ok,
  output logic [47:0]          out_mac_out,
  output logic [1:0]           out_status_out,
  output logic                 out_ignore_out,
  output logic                 out_expired,
  output logic signed [22:0]   out_seconds_delta,
  output logic [31:0]          out_ip_out,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [7:0]  MAX_CNT = 8'(MAX_ENTRIES);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_LK_RD  = 4'd2;
  localparam logic [3:0] S_LK_CHK = 4'd3;
  localparam logic [3:0] S_SW_RD  = 4'd4;
  localparam logic [3:0] S_SW_CHK = 4'd5;
  localparam logic [3:0] S_SWA    = 4'd6;
  localparam logic [3:0] S_SWB    = 4'd7;
  localparam logic [3:0] S_SWW1   = 4'd8;
  localparam logic [3:0] S_SWW2   = 4'd9;
  localparam logic [3:0] S_IG_RD  = 4'd10;
  localparam logic [3:0] S_IG_WR  = 4'd11;
  localparam logic [3:0] S_RD     = 4'd12;
  localparam logic [3:0] S_RD_CHK = 4'd13;
  localparam logic [3:0] S_DIV    = 4'd14;
  localparam logic [3:0] S_DONE   = 4'd15;

  // configuration
  logic [5:0]  lease_count_r;
  logic [31:0] base_ip_r;
  logic [31:0] subnet_mask_r;
  logic [7:0]  start_offset_r;

  // captured command
  logic [2:0]         cmd_r;
  logic [7:0]         ia_r;
  logic [7:0]         ib_r;
  logic [47:0]        mac_r;
  logic signed [31:0] now_r;
  logic [31:0]        exp_r;
  logic [1:0]         st_r;
  logic               ig_r;

  // sequencer and working registers
  logic [3:0]  state_r;
  logic [7:0]  scan_r;
  logic        found_r;
  logic [7:0]  eidx_r;
  entry_t      tmp_r;
  logic        expd_r;
  logic        neg_r;
  logic [31:0] div_r;
  logic [60:0] acc_r;
  logic        mul_step_r;

  // table memory and per-entry valid bits
  entry_t                 lease_mem [MAX_ENTRIES];
  entry_t                 rd_q_r;
  logic                   rd_valid_r;
  logic [MAX_ENTRIES-1:0] valid_r;

  // output register
  logic        out_valid_r;
  logic        out_found_r;
  logic [7:0]  out_entry_index_r;
  logic        out_index_ok_r;
  logic [47:0] out_mac_r;
  logic [1:0]  out_status_r;
  logic        out_ignore_r;
  logic        out_expired_r;
  logic [22:0] out_seconds_r;
  logic [31:0] out_ip_r;

  logic [7:0]       cnt;
  logic             ok_a;
  logic             ok_b;
  logic             ia_in_store;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             del_en;
  entry_t           rd_ent;
  entry_t           rd_sel;
  logic             sweep_hit;
  logic             expd_c;
  logic [31:0]      delta_c;
  logic [15:0]      mul_b;
  logic [47:0]      mul_p;
  logic [22:0]      quo;
  logic [22:0]      sec_full;
  logic [31:0]      ip_masked;
  logic [7:0]       ip_low;
  logic             load_out;

  assign cnt         = ({2'b00, lease_count_r} > MAX_CNT) ? MAX_CNT : {2'b00, lease_count_r};
  assign ok_a        = ia_r < cnt;
  assign ok_b        = ib_r < cnt;
  assign ia_in_store = ia_r < MAX_CNT;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // entries never written since reset or deleted read as blank
  assign rd_ent = rd_valid_r ? rd_q_r : '0;
  assign rd_sel = ia_in_store ? rd_ent : '0;

  assign sweep_hit = (rd_ent.mac != 48'd0) && ($signed(rd_ent.expiry) < now_r);

  assign expd_c  = !($signed(rd_sel.expiry) > now_r);
  assign delta_c = expd_c ? (32'(now_r) - rd_sel.expiry) : (rd_sel.expiry - 32'(now_r));

  // divide by 1000 as a reciprocal multiply, low half first, then high half
  assign mul_b = mul_step_r ? RECIP_MS_HI : RECIP_MS_LO;
  assign mul_p = div_r * mul_b;
  assign quo   = acc_r[RECIP_MS_SHIFT +: 23];

  assign sec_full  = neg_r ? (23'd0 - quo) : quo;
  assign ip_masked = base_ip_r & subnet_mask_r;
  assign ip_low    = ip_masked[7:0] + ia_r + start_offset_r;

  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    unique case (state_r)
      S_LK_RD, S_SW_RD: rd_addr = scan_r[IDX_W-1:0];
      S_SWB:            rd_addr = ib_r[IDX_W-1:0];
      default:          rd_addr = ia_r[IDX_W-1:0];
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ia_r[IDX_W-1:0];
    wr_data = rd_ent;
    del_en  = 1'b0;
    unique case (state_r)
      S_DISP: begin
        if (cmd_r == CMD_WRITE && ok_a) begin
          wr_en   = 1'b1;
          wr_data = '{mac: mac_r, expiry: exp_r, status: st_r, ignore_flag: 1'b0};
        end
        if (cmd_r == CMD_DELETE && ok_a) begin
          del_en = 1'b1;
        end
      end
      S_SW_CHK: begin
        wr_en          = sweep_hit;
        wr_addr        = scan_r[IDX_W-1:0];
        wr_data.status = ST_AVAILABLE;
      end
      S_SWW1: begin
        wr_en          = 1'b1;
        wr_data.status = ST_AVAILABLE;
      end
      S_SWW2: begin
        wr_en          = 1'b1;
        wr_addr        = ib_r[IDX_W-1:0];
        wr_data        = tmp_r;
        wr_data.status = ST_AVAILABLE;
      end
      S_IG_WR: begin
        wr_en               = 1'b1;
        wr_data.ignore_flag = ig_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // table memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      lease_mem[wr_addr] <= wr_data;
    end
    rd_q_r <= lease_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= valid_r[rd_addr];
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end else if (del_en) begin
        valid_r[ia_r[IDX_W-1:0]] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lease_count_r  <= LEASE_COUNT_RST;
      base_ip_r      <= BASE_IP_RST;
      subnet_mask_r  <= SUBNET_MASK_RST;
      start_offset_r <= START_OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LEASE_COUNT:  lease_count_r  <= cfg_data[5:0];
        CFG_BASE_IP:      base_ip_r      <= cfg_data;
        CFG_SUBNET_MASK:  subnet_mask_r  <= cfg_data;
        CFG_START_OFFSET: start_offset_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_command;
      ia_r  <= in_index_a;
      ib_r  <= in_index_b;
      mac_r <= in_mac_in;
      now_r <= in_time_now;
      exp_r <= in_expiry_in;
      st_r  <= in_status_in;
      ig_r  <= in_ignore_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      scan_r     <= '0;
      found_r    <= 1'b0;
      eidx_r     <= '0;
      mul_step_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            found_r <= 1'b0;
            eidx_r  <= '0;
            scan_r  <= '0;
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          unique case (cmd_r)
            CMD_LOOKUP: state_r <= S_LK_RD;
            CMD_SWAP:   state_r <= (ok_a && ok_b) ? S_SWA : S_DONE;
            CMD_IGNORE: state_r <= ia_in_store ? S_IG_RD : S_DONE;
            CMD_READ:   state_r <= S_RD;
            default:    state_r <= S_DONE;
          endcase
        end
        S_LK_RD: begin
          if (scan_r >= cnt) begin
            scan_r  <= '0;
            state_r <= S_SW_RD;
          end else begin
            state_r <= S_LK_CHK;
          end
        end
        S_LK_CHK: begin
          if (rd_ent.mac == mac_r) begin
            found_r <= 1'b1;
            eidx_r  <= scan_r;
            state_r <= S_DONE;
          end else begin
            scan_r  <= scan_r + 8'd1;
            state_r <= S_LK_RD;
          end
        end
        S_SW_RD: begin
          if (scan_r >= cnt) begin
            eidx_r  <= NOT_FOUND;
            state_r <= S_DONE;
          end else begin
            state_r <= S_SW_CHK;
          end
        end
        S_SW_CHK: begin
          scan_r  <= scan_r + 8'd1;
          state_r <= S_SW_RD;
        end
        S_SWA:   state_r <= S_SWB;
        S_SWB:   state_r <= S_SWW1;
        S_SWW1:  state_r <= S_SWW2;
        S_SWW2:  state_r <= S_DONE;
        S_IG_RD: state_r <= S_IG_WR;
        S_IG_WR: state_r <= S_DONE;
        S_RD:    state_r <= S_RD_CHK;
        S_RD_CHK: begin
          mul_step_r <= 1'b0;
          state_r    <= S_DIV;
        end
        S_DIV: begin
          mul_step_r <= 1'b1;
          if (mul_step_r) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // swap holding register and read/divide datapath
  always_ff @(posedge clk) begin
    if (state_r == S_SWB) begin
      tmp_r <= rd_ent;
    end
    if (state_r == S_RD_CHK) begin
      tmp_r  <= rd_sel;
      expd_r <= expd_c;
      neg_r  <= delta_c[31];
      div_r  <= delta_c[31] ? (32'd0 - delta_c) : delta_c;
    end
    if (state_r == S_DIV) begin
      if (!mul_step_r) begin
        acc_r <= {13'd0, mul_p};
      end else begin
        acc_r <= acc_r + {mul_p[44:0], 16'd0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_found_r       <= found_r;
      out_entry_index_r <= eidx_r;
      out_index_ok_r    <= ok_a;
      if (cmd_r == CMD_READ) begin
        out_mac_r     <= tmp_r.mac;
        out_status_r  <= tmp_r.status;
        out_ignore_r  <= tmp_r.ignore_flag;
        out_expired_r <= expd_r;
        out_seconds_r <= sec_full;
        out_ip_r      <= {ip_masked[31:8], ip_low};
      end else begin
        out_mac_r     <= '0;
        out_status_r  <= '0;
        out_ignore_r  <= 1'b0;
        out_expired_r <= 1'b0;
        out_seconds_r <= '0;
        out_ip_r      <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_entry_index   = out_entry_index_r;
  assign out_index_ok      = out_index_ok_r;
  assign out_mac_out       = out_mac_r;
  assign out_status_out    = out_status_r;
  assign out_ignore_out    = out_ignore_r;
  assign out_expired       = out_expired_r;
  assign out_seconds_delta = $signed(out_seconds_r);
  assign out_ip_out        = out_ip_r;

  // divide operand never exceeds 2^31, the largest magnitude of a 32-bit difference
  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_r <= 32'h8000_0000))
    else $error("divide operand out of range");

  // scan never touches an entry outside the active range
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LK_CHK || state_r == S_SW_CHK) |-> (scan_r < cnt))
    else $error("scan index beyond active entries");

  // the table is only written by commands that change it
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_DISP || state_r == S_SW_CHK || state_r == S_SWW1 ||
               state_r == S_SWW2 || state_r == S_IG_WR))
    else $error("unexpected table write");

  // a lookup hit always names an active entry
  a_hit_index: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && found_r) |=> (out_entry_index_r < cnt))
    else $error("lookup hit index out of range");

endmodule
